// ===== hw/rtl/dpq_pkg.sv =====
// Shared types and constants for the double-ended priority queue.
package dpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_MAX = 2'd1,
    CMD_DEL_MIN = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_EMPTY_DELETE = 2'd1,
    ST_FULL_INSERT  = 2'd2,
    ST_UNUSED       = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] command;
    data_t      value;
  } dpq_in_t;

  typedef struct packed {
    data_t      max_value;
    data_t      min_value;
    count_t     occupancy;
    logic       is_empty;
    logic [1:0] status;
  } dpq_out_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic  ins;
    logic  shl;
    data_t data;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/dpq_cell.sv =====
// One cell of the sorted row: holds one value and trades with its neighbors.
module dpq_cell (
  input  logic               clk,
  input  dpq_pkg::cell_ctrl_t ctrl,
  input  logic               valid,
  input  dpq_pkg::data_t     lo_val,
  input  logic               lo_cmp,
  input  dpq_pkg::data_t     hi_val,
  output dpq_pkg::data_t     val,
  output logic               cmp
);
  import dpq_pkg::*;

  data_t val_r;
  data_t val_nxt;

  // An empty cell acts as positive infinity, so the new value lands at the
  // first cell that holds something larger or nothing at all.
  always_comb begin
    cmp     = !valid || (val_r > ctrl.data);
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (lo_cmp) begin
        val_nxt = lo_val;
      end else if (cmp) begin
        val_nxt = ctrl.data;
      end
    end else if (ctrl.shl) begin
      val_nxt = hi_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== hw/rtl/double_ended_priority_queue.sv =====
// The result beat is strobed in the cycle after the command is accepted.
// Busy is high during the result cycle, and a start while busy is not accepted.
// The row of cells compares and shifts in parallel, so any command takes the same time.
// The result cycle selects the maximum from the row by a decode of the count.
// Reset (rst_n low, synchronous) empties the store and clears the controller.
// The receiver cannot stall; each result beat is valid for exactly one cycle.
module double_ended_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dpq_pkg::dpq_in_t  in_data,
  output logic              out_valid,
  output dpq_pkg::dpq_out_t out_data
);
  import dpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_OUT  = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  count_t     count_r, count_nxt;
  status_t    status_r, status_nxt;
  cell_ctrl_t ctrl;
  logic       accept;

  data_t      cell_val [CAPACITY];
  logic       cell_cmp [CAPACITY];
  logic       cell_valid [CAPACITY];

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_OUT);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    ctrl.ins   = 1'b0;
    ctrl.shl   = 1'b0;
    ctrl.data  = in_data.value;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_OUT;
          status_nxt = ST_DONE;
          case (in_data.command)
            CMD_INSERT: begin
              if (count_r >= count_t'(CAPACITY)) begin
                status_nxt = ST_FULL_INSERT;
              end else begin
                ctrl.ins  = 1'b1;
                count_nxt = count_r + count_t'(1);
              end
            end
            CMD_DEL_MAX: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY_DELETE;
              end else begin
                count_nxt = count_r - count_t'(1);
              end
            end
            CMD_DEL_MIN: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY_DELETE;
              end else begin
                ctrl.shl  = 1'b1;
                count_nxt = count_r - count_t'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_valid[i] = count_t'(i) < count_r;
    if (i == 0) begin : g_bottom
      dpq_cell u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .valid  (cell_valid[i]),
        .lo_val ('0),
        .lo_cmp (1'b0),
        .hi_val (cell_val[i+1]),
        .val    (cell_val[i]),
        .cmp    (cell_cmp[i])
      );
    end else if (i == CAPACITY - 1) begin : g_top
      dpq_cell u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .valid  (cell_valid[i]),
        .lo_val (cell_val[i-1]),
        .lo_cmp (cell_cmp[i-1]),
        .hi_val ('0),
        .val    (cell_val[i]),
        .cmp    (cell_cmp[i])
      );
    end else begin : g_mid
      dpq_cell u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .valid  (cell_valid[i]),
        .lo_val (cell_val[i-1]),
        .lo_cmp (cell_cmp[i-1]),
        .hi_val (cell_val[i+1]),
        .val    (cell_val[i]),
        .cmp    (cell_cmp[i])
      );
    end
  end

  // The maximum is the highest occupied cell; its one-hot select is an AND-OR.
  data_t max_sel;
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (count_r == count_t'(i + 1)) begin
        max_sel = max_sel | cell_val[i];
      end
    end
  end

  always_comb begin
    out_valid          = (state_r == S_OUT);
    out_data.max_value = max_sel;
    out_data.min_value = (count_r == '0) ? data_t'(0) : cell_val[0];
    out_data.occupancy = count_r;
    out_data.is_empty  = (count_r == '0);
    out_data.status    = status_r;
  end

endmodule
